>>> sv/rbr_pkg.sv
// Shared types and constants of the radio block reassembler.
`default_nettype none

package rbr_pkg;

    // Packet framing: the payload is what the header leaves of a radio packet.
    localparam int PACKET_BYTES      = 32;
    localparam int HEADER_BYTES      = 4;
    localparam int PAYLOAD_MAX_BYTES = PACKET_BYTES - HEADER_BYTES;
    localparam int DATA_MAX_W        = 8 * PAYLOAD_MAX_BYTES;

    // Defaults for the top-level parameters.
    localparam int MAX_FRAGMENTS_DEF = 16;
    localparam int PAYLOAD_BYTES_DEF = PAYLOAD_MAX_BYTES;

    // Configuration port.
    localparam int          CFG_W            = 16;
    localparam logic [15:0] BYTE_LIMIT_RESET = 16'd32768;
    localparam logic        CFG_DROP_BROKEN  = 1'b0;
    localparam logic        CFG_MAX_BYTES    = 1'b1;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified packet.
    typedef struct packed {
        logic [7:0]            blk_id;
        logic [7:0]            fragment_id;
        logic [7:0]            fragment_count;
        logic [4:0]            size;       // saturated byte count
        logic                  single;     // block of one fragment
        logic                  fid_ok;     // fragment id has a slot
        logic [DATA_MAX_W-1:0] data;       // bytes beyond size zeroed
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_READ,
        ST_LOAD,
        ST_SINGLE
    } t_state;

endpackage

`default_nettype wire

>>> sv/rbr_front.sv
// Front end: saturates the size, clears unused payload bytes and classifies a packet.
`default_nettype none

module rbr_front #(
    parameter int MAX_FRAGMENTS = rbr_pkg::MAX_FRAGMENTS_DEF,
    parameter int PAYLOAD_BYTES = rbr_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic [7:0]  i_blk_id,
    input  wire logic [7:0]  i_fragment_id,
    input  wire logic [7:0]  i_fragment_count,
    input  wire logic [7:0]  i_payload_size,
    input  wire logic [63:0] i_payload_lo,
    input  wire logic [63:0] i_payload_mid,
    input  wire logic [63:0] i_payload_hi,
    input  wire logic [31:0] i_payload_top,
    output rbr_pkg::t_cmd    o_cmd
);

    logic [4:0]                     w_size;
    logic [rbr_pkg::DATA_MAX_W-1:0] w_raw;
    logic [rbr_pkg::DATA_MAX_W-1:0] w_kept;

    assign w_size = (i_payload_size > 8'(PAYLOAD_BYTES)) ? 5'(PAYLOAD_BYTES)
                                                          : i_payload_size[4:0];
    assign w_raw  = {i_payload_top, i_payload_hi, i_payload_mid, i_payload_lo};

    always_comb begin
        for (int k = 0; k < rbr_pkg::PAYLOAD_MAX_BYTES; k++) begin
            w_kept[8*k +: 8] = (5'(k) < w_size) ? w_raw[8*k +: 8] : 8'd0;
        end
    end

    always_comb begin
        o_cmd.blk_id         = i_blk_id;
        o_cmd.fragment_id    = i_fragment_id;
        o_cmd.fragment_count = i_fragment_count;
        o_cmd.size           = w_size;
        o_cmd.single         = (i_fragment_count == 8'd1);
        o_cmd.fid_ok         = (i_fragment_id < 8'(MAX_FRAGMENTS));
        o_cmd.data           = w_kept;
    end

endmodule

`default_nettype wire

>>> sv/rbr_fifo.sv
// Two-entry command queue between front and back.
`default_nettype none

module rbr_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  rbr_pkg::t_cmd  i_cmd,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_valid,
    output rbr_pkg::t_cmd  o_cmd
);

    rbr_pkg::t_cmd                   r_entry [rbr_pkg::QUEUE_DEPTH];
    logic                            r_wr_ptr;
    logic                            r_rd_ptr;
    logic [rbr_pkg::QUEUE_CNT_W-1:0] r_count;
    logic [rbr_pkg::QUEUE_CNT_W-1:0] n_count;

    assign o_full  = (r_count == rbr_pkg::QUEUE_CNT_W'(rbr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_cmd;
    end

endmodule

`default_nettype wire

>>> sv/rbr_back.sv
// Back end: block tracking, slot store, completion walk and piece output.
`default_nettype none

module rbr_back #(
    parameter int MAX_FRAGMENTS = rbr_pkg::MAX_FRAGMENTS_DEF,
    parameter int PAYLOAD_BYTES = rbr_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  rbr_pkg::t_cmd                        i_q_cmd,
    output logic                                 o_q_pop,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [rbr_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic [rbr_pkg::DATA_MAX_W-1:0]       o_out_data,
    output logic [4:0]                           o_out_size,
    output logic                                 o_out_last
);

    localparam int DATA_W = 8 * PAYLOAD_BYTES;
    localparam int IDX_W  = $clog2(MAX_FRAGMENTS);
    localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);

    rbr_pkg::t_state r_state;
    rbr_pkg::t_state n_state;
    rbr_pkg::t_cmd   r_cmd;

    logic [7:0]        r_cur;
    logic [7:0]        r_exp;
    logic              r_done;
    logic              r_drop;
    logic [15:0]       r_max;
    logic [CNT_W-1:0]  r_i;
    logic [15:0]       r_total;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_j;
    logic [4:0]        r_slot_size [MAX_FRAGMENTS];
    logic [DATA_W-1:0] r_slot_mem  [MAX_FRAGMENTS];
    logic [DATA_W-1:0] r_rdata;

    logic                           r_out_valid;
    logic [rbr_pkg::DATA_MAX_W-1:0] r_out_data;
    logic [4:0]                     r_out_size;
    logic                           r_out_last;

    // decode of the current command
    logic       w_same, w_ignore, w_new;
    logic [7:0] w_exp_eff;
    logic       w_not_last;
    // walk
    logic       w_at_end, w_broken;
    logic [4:0] w_s;
    logic [16:0] w_sum;
    // output side
    logic       w_out_free, w_last_piece;
    // controls
    logic       w_upd_block, w_store, w_walk_step, w_walk_fin, w_deliver;
    logic       w_load_single, w_load_piece;

    assign w_same     = (r_cmd.blk_id == r_cur);
    assign w_ignore   = w_same && r_done;
    assign w_new      = !w_same;
    assign w_exp_eff  = w_new ? r_cmd.fragment_count : r_exp;
    assign w_not_last = ({1'b0, r_cmd.fragment_id} + 9'd1) < {1'b0, w_exp_eff};

    assign w_at_end = (8'(r_i) >= r_exp);
    assign w_s      = (r_i < CNT_W'(MAX_FRAGMENTS)) ? r_slot_size[r_i[IDX_W-1:0]] : 5'd0;
    assign w_sum    = {1'b0, r_total} + {12'd0, w_s};
    assign w_broken = !w_at_end && ((w_s == 5'd0) || (w_sum >= {1'b0, r_max}));

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_last_piece = (({1'b0, r_j} + 1'b1) == {1'b0, r_n});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbr_pkg::ST_IDLE: begin
                if (i_q_valid) n_state = rbr_pkg::ST_EXEC;
            end
            rbr_pkg::ST_EXEC: begin
                priority if (w_ignore)       n_state = rbr_pkg::ST_IDLE;
                else if (r_cmd.single)       n_state = (r_cmd.size != 5'd0) ?
                                                       rbr_pkg::ST_SINGLE : rbr_pkg::ST_IDLE;
                else if (!r_cmd.fid_ok)      n_state = rbr_pkg::ST_IDLE;
                else if (w_not_last)         n_state = rbr_pkg::ST_IDLE;
                else                         n_state = rbr_pkg::ST_WALK;
            end
            rbr_pkg::ST_WALK: begin
                if (w_at_end || w_broken) begin
                    if ((r_drop && !w_at_end) || (r_i == '0)) n_state = rbr_pkg::ST_IDLE;
                    else                                      n_state = rbr_pkg::ST_READ;
                end
            end
            rbr_pkg::ST_READ: begin
                n_state = rbr_pkg::ST_LOAD;
            end
            rbr_pkg::ST_LOAD: begin
                if (w_out_free) n_state = w_last_piece ? rbr_pkg::ST_IDLE : rbr_pkg::ST_READ;
            end
            rbr_pkg::ST_SINGLE: begin
                if (w_out_free) n_state = rbr_pkg::ST_IDLE;
            end
            default: n_state = rbr_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop       = 1'b0;
        w_upd_block   = 1'b0;
        w_store       = 1'b0;
        w_walk_step   = 1'b0;
        w_walk_fin    = 1'b0;
        w_deliver     = 1'b0;
        w_load_single = 1'b0;
        w_load_piece  = 1'b0;
        unique case (r_state)
            rbr_pkg::ST_IDLE:   o_q_pop = i_q_valid;
            rbr_pkg::ST_EXEC: begin
                w_upd_block = !w_ignore;
                w_store     = !w_ignore && !r_cmd.single && r_cmd.fid_ok;
            end
            rbr_pkg::ST_WALK: begin
                w_walk_fin  = w_at_end || w_broken;
                w_walk_step = !w_walk_fin;
                w_deliver   = w_walk_fin && !(r_drop && !w_at_end);
            end
            rbr_pkg::ST_READ:   ;
            rbr_pkg::ST_LOAD:   w_load_piece  = w_out_free;
            rbr_pkg::ST_SINGLE: w_load_single = w_out_free;
            default:            ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbr_pkg::ST_IDLE;
            r_cur       <= 8'd0;
            r_exp       <= 8'd0;
            r_done      <= 1'b0;
            r_drop      <= 1'b1;
            r_max       <= rbr_pkg::BYTE_LIMIT_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_FRAGMENTS; k++) r_slot_size[k] <= 5'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rbr_pkg::CFG_DROP_BROKEN: r_drop <= i_cfg_data[0];
                    rbr_pkg::CFG_MAX_BYTES:   r_max  <= i_cfg_data;
                    default:                  ;
                endcase
            end
            if (w_upd_block) begin
                r_cur <= r_cmd.blk_id;
                if (w_new) begin
                    r_exp  <= r_cmd.fragment_count;
                    r_done <= 1'b0;
                    for (int k = 0; k < MAX_FRAGMENTS; k++) r_slot_size[k] <= 5'd0;
                end
                if (r_cmd.single) r_done <= 1'b1;
            end
            if (w_store) r_slot_size[r_cmd.fragment_id[IDX_W-1:0]] <= r_cmd.size;
            if (w_deliver) r_done <= 1'b1;
            if (w_load_single || w_load_piece) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_cmd;
        if (r_state == rbr_pkg::ST_EXEC) begin
            r_i     <= '0;
            r_total <= 16'd0;
        end
        if (w_walk_step) begin
            r_i     <= r_i + 1'b1;
            r_total <= w_sum[15:0];
        end
        if (w_walk_fin) begin
            r_n <= r_i;
            r_j <= '0;
        end
        if (w_load_piece) r_j <= r_j + 1'b1;
        if (w_load_single) begin
            r_out_data <= r_cmd.data;
            r_out_size <= r_cmd.size;
            r_out_last <= 1'b1;
        end
        if (w_load_piece) begin
            r_out_data <= rbr_pkg::DATA_MAX_W'(r_rdata);
            r_out_size <= r_slot_size[r_j[IDX_W-1:0]];
            r_out_last <= w_last_piece;
        end
    end

    // slot payload memory
    always_ff @(posedge i_clk) begin
        if (w_store) r_slot_mem[r_cmd.fragment_id[IDX_W-1:0]] <= r_cmd.data[DATA_W-1:0];
        r_rdata <= r_slot_mem[r_j[IDX_W-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_size  = r_out_size;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

>>> sv/radio_block_reassembler_core.sv
// Top level of the radio block reassembler.
//
// Input channel: one received radio packet per word (block id, fragment id,
// fragment count, payload size, 28 payload bytes), taken when i_in_valid is
// high and o_in_stall low. o_in_stall rises only when the two-word command
// queue is full.
// Output channel: one reassembled piece per word, shown while o_out_valid is
// high and held until a cycle with i_out_stall low. o_out_last marks the
// final piece of a block.
// Back end: a packet that stores a fragment or is ignored passes from IDLE
// through EXEC and back; a single-fragment block goes from the queue through
// EXEC and SINGLE into the output register. Completing a block walks the slot
// sizes one slot a cycle, then sends each piece through the READ and LOAD
// states, gated by the slot memory's registered read port.
// A stalled receiver holds the output register; the back end waits on it and
// the queue in front keeps taking packets until full.
// Reset (synchronous, active low) empties the queue and output, clears all
// slot sizes and block state and restores drop_broken = 1 and the byte limit
// of 32768. Configuration writes (index 0: drop_broken, 1: max_block_bytes)
// are taken in any cycle and are meant for idle periods.
`default_nettype none

module radio_block_reassembler_core #(
    parameter int MAX_FRAGMENTS = rbr_pkg::MAX_FRAGMENTS_DEF,
    parameter int PAYLOAD_BYTES = rbr_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // packet input
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_blk_id,
    input  wire logic [7:0]                i_fragment_id,
    input  wire logic [7:0]                i_fragment_count,
    input  wire logic [7:0]                i_payload_size,
    input  wire logic [63:0]               i_payload_lo,
    input  wire logic [63:0]               i_payload_mid,
    input  wire logic [63:0]               i_payload_hi,
    input  wire logic [31:0]               i_payload_top,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [rbr_pkg::CFG_W-1:0] i_cfg_data,
    // piece output
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [63:0]                    o_out_lo,
    output logic [63:0]                    o_out_mid,
    output logic [63:0]                    o_out_hi,
    output logic [31:0]                    o_out_top,
    output logic [4:0]                     o_out_size,
    output logic                           o_out_last
);

    rbr_pkg::t_cmd                  w_front_cmd;
    rbr_pkg::t_cmd                  w_q_cmd;
    logic                           w_push;
    logic                           w_q_full;
    logic                           w_q_valid;
    logic                           w_q_pop;
    logic [rbr_pkg::DATA_MAX_W-1:0] w_out_data;

    // front: classify the packet on the way into the queue
    rbr_front #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_blk_id         (i_blk_id),
        .i_fragment_id    (i_fragment_id),
        .i_fragment_count (i_fragment_count),
        .i_payload_size   (i_payload_size),
        .i_payload_lo     (i_payload_lo),
        .i_payload_mid    (i_payload_mid),
        .i_payload_hi     (i_payload_hi),
        .i_payload_top    (i_payload_top),
        .o_cmd            (w_front_cmd)
    );

    assign o_in_stall = w_q_full;
    assign w_push     = i_in_valid && !w_q_full;

    rbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // back: block state, slot store, completion walk, output register
    rbr_back #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (w_out_data),
        .o_out_size  (o_out_size),
        .o_out_last  (o_out_last)
    );

    assign o_out_lo  = w_out_data[63:0];
    assign o_out_mid = w_out_data[127:64];
    assign o_out_hi  = w_out_data[191:128];
    assign o_out_top = w_out_data[223:192];

endmodule

`default_nettype wire

>>> sv/rbr_checker.sv
// Port-level checks of the reassembler, bound to the top level.
`default_nettype none

module rbr_checker #(
    parameter int PAYLOAD_BYTES = rbr_pkg::PAYLOAD_BYTES_DEF
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [63:0]               o_out_lo,
    input wire logic [63:0]               o_out_mid,
    input wire logic [63:0]               o_out_hi,
    input wire logic [31:0]               o_out_top,
    input wire logic [4:0]                o_out_size,
    input wire logic                      o_out_last
);

    // a stalled word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word withdrawn while stalled");

    // a stalled word keeps its low bytes, size and last flag
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_lo) && $stable(o_out_size) && $stable(o_out_last))
        else $error("output word changed while stalled");

    // pieces are never empty and never exceed the payload
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_size != 5'd0) && (o_out_size <= 5'(PAYLOAD_BYTES)))
        else $error("piece size out of range");

    // a piece of at most 8 bytes has zero bytes beyond the first 8
    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_size <= 5'd8) |->
            (o_out_mid == 64'd0) && (o_out_hi == 64'd0) && (o_out_top == 32'd0))
        else $error("bytes beyond piece size not cleared");

endmodule

bind radio_block_reassembler_core rbr_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_rbr_checker (.*);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the radio block reassembler core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAGS     = rbr_pkg::MAX_FRAGMENTS_DEF;
    localparam int PAY_BYTES     = rbr_pkg::PAYLOAD_BYTES_DEF;
    localparam int PAY_W         = 8 * PAY_BYTES;
    localparam int RESET_CYCLES  = 9;
    // Longest quiet spell the core may need after the last piece: two queued
    // packets plus a full slot walk, with plenty of margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;

    // One received radio packet as it sits on the input channel.
    typedef struct packed {
        logic [7:0]       blk_id;
        logic [7:0]       fragment_id;
        logic [7:0]       fragment_count;
        logic [7:0]       payload_size;
        logic [PAY_W-1:0] payload;      // byte 0 in the low bits
    } t_packet;

    // One reassembled piece as the output channel should show it.
    typedef struct packed {
        logic [PAY_W-1:0] bytes;
        logic [4:0]       size;
        logic             last;
    } t_piece;

    // ------------------------------------------------------------------
    // Clock, reset and the signals into the core
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    t_packet        pkt_on_bus  = '0;
    logic           i_cfg_we    = 1'b0;
    logic           i_cfg_idx   = 1'b0;
    logic [rbr_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    logic [63:0]    o_out_lo;
    logic [63:0]    o_out_mid;
    logic [63:0]    o_out_hi;
    logic [31:0]    o_out_top;
    logic [4:0]     o_out_size;
    logic           o_out_last;

    radio_block_reassembler_core #(
        .MAX_FRAGMENTS (MAX_FRAGS),
        .PAYLOAD_BYTES (PAY_BYTES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_blk_id         (pkt_on_bus.blk_id),
        .i_fragment_id    (pkt_on_bus.fragment_id),
        .i_fragment_count (pkt_on_bus.fragment_count),
        .i_payload_size   (pkt_on_bus.payload_size),
        .i_payload_lo     (pkt_on_bus.payload[63:0]),
        .i_payload_mid    (pkt_on_bus.payload[127:64]),
        .i_payload_hi     (pkt_on_bus.payload[191:128]),
        .i_payload_top    (pkt_on_bus.payload[223:192]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_lo         (o_out_lo),
        .o_out_mid        (o_out_mid),
        .o_out_hi         (o_out_hi),
        .o_out_top        (o_out_top),
        .o_out_size       (o_out_size),
        .o_out_last       (o_out_last)
    );

    // ------------------------------------------------------------------
    // Reassembly predictor: own copy of slot store, block state and config
    // ------------------------------------------------------------------
    t_packet          packets_pending [$];
    t_piece           pieces_due [$];

    logic [7:0]       blk_cur   = 8'd0;
    logic [7:0]       blk_count = 8'd0;
    logic             blk_done  = 1'b0;
    int               frag_len [MAX_FRAGS] = '{default: 0};
    logic [PAY_W-1:0] frag_bytes [MAX_FRAGS];
    logic             cfg_drop  = 1'b1;
    int               cfg_limit = 32768;

    int               n_errors  = 0;
    logic [7:0]       recent_block = 8'd0;  // block id of the last packet queued

    // zero every byte at or beyond len
    function automatic logic [PAY_W-1:0] clip_payload(input logic [PAY_W-1:0] d,
                                                      input int len);
        logic [PAY_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < len; b++) mask[8*b +: 8] = 8'hFF;
        return d & mask;
    endfunction

    // Work out what one accepted packet does and queue the pieces it releases.
    function automatic void apply_packet(input t_packet p);
        int               len;
        int               total;
        int               n;
        int               s;
        logic             whole;
        logic [PAY_W-1:0] data;
        len  = (p.payload_size > PAY_BYTES) ? PAY_BYTES : int'(p.payload_size);
        data = clip_payload(p.payload, len);
        // late packets of a finished block are ignored
        if (p.blk_id == blk_cur && blk_done) return;
        if (p.blk_id != blk_cur) begin
            foreach (frag_len[i]) frag_len[i] = 0;
            blk_cur   = p.blk_id;
            blk_count = p.fragment_count;
            blk_done  = 1'b0;
        end
        if (p.fragment_count == 8'd1) begin
            blk_done = 1'b1;
            if (len != 0) pieces_due.push_back('{data, 5'(len), 1'b1});
            return;
        end
        if (p.fragment_id >= MAX_FRAGS) return;
        frag_bytes[p.fragment_id] = data;
        frag_len[p.fragment_id]   = len;
        if (int'(p.fragment_id) + 1 < int'(blk_count)) return;
        // last id seen: walk the slots for the valid prefix
        whole = 1'b1;
        total = 0;
        n     = 0;
        for (int i = 0; i < int'(blk_count); i++) begin
            s = (i < MAX_FRAGS) ? frag_len[i] : 0;
            if (s == 0 || total + s >= cfg_limit) begin
                whole = 1'b0;
                break;
            end
            total += s;
            n++;
        end
        // a dropped block stays open, so a later fragment can retry it
        if (cfg_drop && !whole) return;
        blk_done = 1'b1;
        for (int i = 0; i < n; i++)
            pieces_due.push_back('{frag_bytes[i], 5'(frag_len[i]), (i + 1 == n)});
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [PAY_W-1:0] rand_payload();
        logic [PAY_W-1:0] v;
        int               r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        for (int k = 0; k < PAY_W / 32; k++) v[32*k +: 32] = $urandom();
        return v;
    endfunction

    // non-zero size, now and then oversized (saturates to a full payload)
    function automatic logic [7:0] good_size();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(PAY_BYTES + 1, 255));
        return 8'($urandom_range(1, PAY_BYTES));
    endfunction

    function automatic logic [7:0] any_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 22) return 8'($urandom_range(PAY_BYTES + 1, 255));
        return 8'($urandom_range(1, PAY_BYTES));
    endfunction

    function automatic void post_packet(input logic [7:0] bid, input logic [7:0] fid,
                                        input logic [7:0] cnt, input logic [7:0] size,
                                        input logic [PAY_W-1:0] data);
        packets_pending.push_back('{bid, fid, cnt, size, data});
        recent_block = bid;
    endfunction

    function automatic logic [7:0] fresh_blk_id();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == recent_block);
        return b;
    endfunction

    // A block of n fragments, last id last; a broken one loses a fragment or
    // carries it with zero size, and may have it turn up late.
    function automatic void post_block(input int n, input bit broken);
        logic [7:0] bid;
        int         order [MAX_FRAGS];
        int         hole;
        int         a;
        int         b;
        int         t;
        bit         skip;
        bid = fresh_blk_id();
        for (int i = 0; i < n; i++) order[i] = i;
        if (n > 2 && $urandom_range(0, 1) == 1) begin
            a        = $urandom_range(0, n - 2);
            b        = $urandom_range(0, n - 2);
            t        = order[a];
            order[a] = order[b];
            order[b] = t;
        end
        hole = broken ? $urandom_range(0, n - 1) : -1;
        skip = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
            if (order[i] != hole)
                post_packet(bid, 8'(order[i]), 8'(n), good_size(), rand_payload());
            else if (!skip)
                post_packet(bid, 8'(order[i]), 8'(n), 8'd0, rand_payload());
        end
        if (broken && hole != n - 1 && $urandom_range(0, 1) == 1) begin
            post_packet(bid, 8'(hole), 8'(n), good_size(), rand_payload());
            post_packet(bid, 8'(n - 1), 8'(n), good_size(), rand_payload());
        end
    endfunction

    // Mostly well-formed blocks with random content, the rest odd cases and noise.
    function automatic void random_traffic(input int target);
        int         queued;
        int         r;
        int         n;
        logic [7:0] bid;
        queued = 0;
        while (queued < target) begin
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, MAX_FRAGS)
                                            : $urandom_range(2, 6);
            if (r < 52) begin
                post_block(n, 1'b0);
                queued += n;
            end else if (r < 64) begin
                post_block(n, 1'b1);
                queued += n;
            end else if (r < 74) begin
                post_packet(fresh_blk_id(), 8'($urandom_range(0, 255)), 8'd1,
                            any_size(), rand_payload());
                queued++;
            end else if (r < 80) begin
                // more of the latest block: ignored if it already finished
                post_packet(recent_block, 8'($urandom_range(0, MAX_FRAGS - 1)),
                            8'($urandom_range(0, 3)), any_size(), rand_payload());
            end else if (r < 85) begin
                post_packet(fresh_blk_id(), 8'($urandom_range(0, MAX_FRAGS - 1)), 8'd0,
                            any_size(), rand_payload());
                queued++;
            end else if (r < 90) begin
                // count beyond the slots: can never complete
                bid = fresh_blk_id();
                n   = $urandom_range(MAX_FRAGS + 1, 255);
                post_packet(bid, 8'($urandom_range(0, MAX_FRAGS - 1)), 8'(n),
                            good_size(), rand_payload());
                post_packet(bid, 8'($urandom_range(MAX_FRAGS, 255)), 8'(n),
                            good_size(), rand_payload());
                post_packet(bid, 8'(MAX_FRAGS - 1), 8'(n), good_size(), rand_payload());
                queued += 2;
            end else begin
                post_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            rand_payload());
                queued++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Packet driver: one word per accept, random gaps between words
    // ------------------------------------------------------------------
    int send_gap    = 0;
    int quiet_words = 0;

    function automatic int pick_gap();
        int r;
        if (quiet_words != 0) begin
            quiet_words--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 52) return 0;
        if (r < 55) begin
            // a stretch of back-to-back words
            quiet_words = $urandom_range(20, 60);
            return 0;
        end
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) apply_packet(pkt_on_bus);
            // the payload only moves once the word on the bus has gone
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (packets_pending.size() != 0) begin
                    pkt_on_bus <= packets_pending[0];
                    packets_pending.delete(0);
                    i_in_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here; armed once from the sequence
    // ------------------------------------------------------------------
    int   hold_left  = 0;
    bit   hold_armed = 1'b0;
    bit   hold_used  = 1'b0;
    logic holding;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used) begin
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end
    end

    assign holding = (hold_left != 0);

    // ------------------------------------------------------------------
    // Piece monitor: check each accepted word, then pick the next stall
    // ------------------------------------------------------------------
    int stall_left = 0;
    int run_left   = 0;

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch_pieces
        t_piece want;
        logic   stall_now;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pieces_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("piece with none pending: size %0d last %0d lo %h",
                                 o_out_size, o_out_last, o_out_lo);
                end else begin
                    want = pieces_due[0];
                    pieces_due.delete(0);
                    check_field("out_lo",   want.bytes[63:0],    o_out_lo);
                    check_field("out_mid",  want.bytes[127:64],  o_out_mid);
                    check_field("out_hi",   want.bytes[191:128], o_out_hi);
                    check_field("out_top",  64'(want.bytes[223:192]), 64'(o_out_top));
                    check_field("out_size", 64'(want.size),           64'(o_out_size));
                    check_field("out_last", 64'(want.last),           64'(o_out_last));
                end
            end
            if (holding) begin
                stall_now = 1'b1;
            end else if (stall_left != 0) begin
                stall_now = 1'b1;
                stall_left--;
            end else if (run_left != 0) begin
                stall_now = 1'b0;
                run_left--;
            end else begin
                // next open run, then a stall: mostly short, now and then long
                stall_now  = 1'b0;
                run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(0, 8);
                stall_left = $urandom_range(0, 99);
                if (stall_left < 65)      stall_left = $urandom_range(1, 2);
                else if (stall_left < 93) stall_left = $urandom_range(3, 8);
                else                      stall_left = $urandom_range(20, 60);
            end
            i_out_stall <= stall_now;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed start, then random phases under several settings
    // ------------------------------------------------------------------
    task automatic wait_quiet();
        while (packets_pending.size() != 0 || i_in_valid || pieces_due.size() != 0)
            @(posedge i_clk);
        // a trailing packet may release nothing yet keep the core busy a while
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [rbr_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == rbr_pkg::CFG_DROP_BROKEN) cfg_drop = val[0];
        else                                 cfg_limit = int'(val);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: broken blocks dropped, limit 32768.
        // single fragment, full payload, block id equal to the reset id
        post_packet(8'd0, 8'd0, 8'd1, 8'd28, '1);
        // finished block again: ignored
        post_packet(8'd0, 8'd0, 8'd1, 8'd5, rand_payload());
        // oversized single with every id bit high
        post_packet(8'd255, 8'd255, 8'd1, 8'd255, rand_payload());
        // zero-byte single: nothing out, block closed
        post_packet(8'd1, 8'd3, 8'd1, 8'd0, '1);
        // three fragments, two with partial payloads
        post_packet(8'd2, 8'd0, 8'd3, 8'd1, '1);
        post_packet(8'd2, 8'd1, 8'd3, 8'd13, rand_payload());
        post_packet(8'd2, 8'd2, 8'd3, 8'd28, '0);
        // zero fragment count: closes with nothing, then ignored
        post_packet(8'd3, 8'd4, 8'd0, 8'd9, rand_payload());
        post_packet(8'd3, 8'd0, 8'd1, 8'd9, rand_payload());
        // out-of-range id, empty last slot dropped, then a retry that completes
        post_packet(8'd4, 8'd200, 8'd2, 8'd9, rand_payload());
        post_packet(8'd4, 8'd1, 8'd2, 8'd0, rand_payload());
        post_packet(8'd4, 8'd0, 8'd2, 8'd10, rand_payload());
        post_packet(8'd4, 8'd1, 8'd2, 8'd7, rand_payload());
        // count beyond the slots never completes
        post_packet(8'd5, 8'd0, 8'd255, 8'd20, rand_payload());
        post_packet(8'd5, 8'd15, 8'd255, 8'd20, rand_payload());
        post_packet(8'd5, 8'd255, 8'd255, 8'd20, rand_payload());
        // all sixteen slots expected, only the last filled: dropped
        post_packet(8'd6, 8'd15, 8'd16, 8'd28, rand_payload());
        wait_quiet();

        // Emit valid prefixes, limit at the top of the register.
        write_cfg(rbr_pkg::CFG_DROP_BROKEN, 16'd0);
        write_cfg(rbr_pkg::CFG_MAX_BYTES, 16'hFFFF);
        post_packet(8'd7, 8'd0, 8'd4, 8'd8, rand_payload());
        post_packet(8'd7, 8'd1, 8'd4, 8'd0, rand_payload());
        post_packet(8'd7, 8'd3, 8'd4, 8'd4, rand_payload());
        post_packet(8'd7, 8'd2, 8'd4, 8'd4, rand_payload());
        post_packet(8'd6, 8'd15, 8'd16, 8'd28, rand_payload());
        random_traffic(125);
        wait_quiet();

        // Tight limit so that larger blocks overflow.
        write_cfg(rbr_pkg::CFG_DROP_BROKEN, 16'd1);
        write_cfg(rbr_pkg::CFG_MAX_BYTES, 16'd100);
        random_traffic(110);
        wait_quiet();

        // Limit of zero and of one: only singles get through.
        write_cfg(rbr_pkg::CFG_DROP_BROKEN, 16'd0);
        write_cfg(rbr_pkg::CFG_MAX_BYTES, 16'd0);
        random_traffic(25);
        wait_quiet();
        write_cfg(rbr_pkg::CFG_MAX_BYTES, 16'd1);
        random_traffic(25);
        wait_quiet();

        // Back to reset values, with the receiver holding off for a while.
        write_cfg(rbr_pkg::CFG_DROP_BROKEN, 16'd1);
        write_cfg(rbr_pkg::CFG_MAX_BYTES, rbr_pkg::BYTE_LIMIT_RESET);
        random_traffic(150);
        hold_armed = 1'b1;
        wait_quiet();

        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Slowest legal run is well under 5 ms (every word waiting out the longest
    // gaps and stalls); allow five times that.
    initial begin
        #25_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> radio_block_reassembler_core.f
sv/rbr_pkg.sv
sv/rbr_front.sv
sv/rbr_fifo.sv
sv/rbr_back.sv
sv/radio_block_reassembler_core.sv
sv/rbr_checker.sv
test/testbench.sv
